// ----- src/assert_macros.svh -----
// Assertion helpers for the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked every cycle outside reset
`define UDM_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication outside reset
`define UDM_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- src/udm_pkg.sv -----
package udm_pkg;

    localparam int IMAGE_WIDTH  = 640;
    localparam int IMAGE_HEIGHT = 480;

    localparam int PIX_X_W   = 10;
    localparam int PIX_Y_W   = 9;
    localparam int CFG_W     = 22;
    localparam int COEF_W    = 16;
    localparam int FX_W      = 25;
    localparam int DIV_STEPS = FX_W;
    localparam int IDX_W     = 3;
    localparam int DATA_W    = 32;

    localparam logic signed [FX_W-1:0] FX_MAX_Q = 25'sh0FFFFFF;
    localparam logic signed [FX_W-1:0] FX_MIN_Q = 25'sh1000000;
    localparam logic signed [63:0]     FX_MAX   = 64'sd16777215;
    localparam logic signed [63:0]     FX_MIN   = -64'sd16777216;
    localparam logic signed [63:0]     FX_ONE   = 64'sd1048576;

    localparam logic [CFG_W-1:0] FOCAL_X_RST  = 22'd584192;
    localparam logic [CFG_W-1:0] FOCAL_Y_RST  = 22'd584192;
    localparam logic [CFG_W-1:0] CENTRE_X_RST = 22'd327680;
    localparam logic [CFG_W-1:0] CENTRE_Y_RST = 22'd245760;

    typedef enum logic [IDX_W-1:0] {
        CFG_FOCAL_X  = 3'd0,
        CFG_FOCAL_Y  = 3'd1,
        CFG_CENTRE_X = 3'd2,
        CFG_CENTRE_Y = 3'd3,
        CFG_K1       = 3'd4,
        CFG_K2       = 3'd5,
        CFG_K3       = 3'd6,
        CFG_TANG     = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0]         focal_x;
        logic [CFG_W-1:0]         focal_y;
        logic [CFG_W-1:0]         centre_x;
        logic [CFG_W-1:0]         centre_y;
        logic signed [COEF_W-1:0] radial_k1;
        logic signed [COEF_W-1:0] radial_k2;
        logic signed [COEF_W-1:0] radial_k3;
        logic signed [COEF_W-1:0] tang_p1;
        logic signed [COEF_W-1:0] tang_p2;
    } cfg_t;

    function automatic logic signed [FX_W-1:0] sat_fx(input logic signed [63:0] v);
        if (v > FX_MAX) begin
            return FX_MAX_Q;
        end else if (v < FX_MIN) begin
            return FX_MIN_Q;
        end else begin
            return v[FX_W-1:0];
        end
    endfunction

endpackage

// ----- src/udm_cfg.sv -----
module udm_cfg (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic [udm_pkg::IDX_W-1:0] cfg_index,
    input  logic [udm_pkg::DATA_W-1:0] cfg_data,
    output udm_pkg::cfg_t             cfg
);
    import udm_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        unique case (cfg_index)
            CFG_FOCAL_X:  cfg_next.focal_x   = cfg_data[CFG_W-1:0];
            CFG_FOCAL_Y:  cfg_next.focal_y   = cfg_data[CFG_W-1:0];
            CFG_CENTRE_X: cfg_next.centre_x  = cfg_data[CFG_W-1:0];
            CFG_CENTRE_Y: cfg_next.centre_y  = cfg_data[CFG_W-1:0];
            CFG_K1:       cfg_next.radial_k1 = $signed(cfg_data[COEF_W-1:0]);
            CFG_K2:       cfg_next.radial_k2 = $signed(cfg_data[COEF_W-1:0]);
            CFG_K3:       cfg_next.radial_k3 = $signed(cfg_data[COEF_W-1:0]);
            CFG_TANG:
            begin
                cfg_next.tang_p1 = $signed(cfg_data[COEF_W-1:0]);
                cfg_next.tang_p2 = $signed(cfg_data[2*COEF_W-1:COEF_W]);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.focal_x   <= FOCAL_X_RST;
            cfg_reg.focal_y   <= FOCAL_Y_RST;
            cfg_reg.centre_x  <= CENTRE_X_RST;
            cfg_reg.centre_y  <= CENTRE_Y_RST;
            cfg_reg.radial_k1 <= '0;
            cfg_reg.radial_k2 <= '0;
            cfg_reg.radial_k3 <= '0;
            cfg_reg.tang_p1   <= '0;
            cfg_reg.tang_p2   <= '0;
        end
        else if (cfg_valid)
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- src/udm_norm.sv -----
module udm_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  udm_pkg::cfg_t                      cfg,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [udm_pkg::PIX_X_W-1:0]        pixel_x,
    input  logic [udm_pkg::PIX_Y_W-1:0]        pixel_y,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [udm_pkg::FX_W-1:0]    nx,
    output logic signed [udm_pkg::FX_W-1:0]    ny
);
    import udm_pkg::*;

    localparam int NST = DIV_STEPS + 2;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] go;

    logic [CFG_W-1:0]        focal [2];
    logic signed [23:0]      d_next [2];
    logic [23:0]             abs_d [2];

    logic [CFG_W-1:0]        rem_reg  [2][DIV_STEPS+1];
    logic [CFG_W-1:0]        rem_next [2][DIV_STEPS+1];
    logic [FX_W-1:0]         w_reg    [2][DIV_STEPS+1];
    logic [FX_W-1:0]         w_next   [2][DIV_STEPS+1];
    logic                    neg_reg  [2][DIV_STEPS+1];
    logic                    neg_next [2][DIV_STEPS+1];
    logic                    ovf_reg  [2][DIV_STEPS+1];
    logic                    ovf_next [2][DIV_STEPS+1];
    logic                    zero_reg [2][DIV_STEPS+1];
    logic                    zero_next[2][DIV_STEPS+1];
    logic [CFG_W:0]          trial    [2][DIV_STEPS+1];
    logic                    ge       [2][DIV_STEPS+1];

    logic signed [FX_W-1:0]  n_reg  [2];
    logic signed [FX_W-1:0]  n_next [2];
    logic                    big    [2];

    assign focal[0] = cfg.focal_x;
    assign focal[1] = cfg.focal_y;

    assign d_next[0] = $signed({4'b0, pixel_x, 10'b0}) + 24'sd512
                     - $signed({2'b0, cfg.centre_x});
    assign d_next[1] = $signed({5'b0, pixel_y, 10'b0}) + 24'sd512
                     - $signed({2'b0, cfg.centre_y});

    always_comb
    begin
        go[NST-1] = !v_reg[NST-1] || out_ready;
        for (int i = NST - 2; i >= 0; i--)
        begin
            go[i] = !v_reg[i] || go[i+1];
        end
    end

    // restoring division of |d| << 20 by focal, one quotient bit per stage
    always_comb
    begin
        for (int a = 0; a < 2; a++)
        begin
            abs_d[a]        = d_next[a][23] ? 24'(-d_next[a]) : 24'(d_next[a]);
            neg_next[a][0]  = d_next[a][23];
            zero_next[a][0] = (abs_d[a] == '0);
            ovf_next[a][0]  = {5'b0, abs_d[a][CFG_W-1:0]} >= {focal[a], 5'b0};
            rem_next[a][0]  = {5'b0, abs_d[a][CFG_W-1:5]};
            w_next[a][0]    = {abs_d[a][4:0], 20'b0};
            trial[a][0]     = '0;
            ge[a][0]        = 1'b0;
            for (int s = 1; s <= DIV_STEPS; s++)
            begin
                trial[a][s]     = {rem_reg[a][s-1], w_reg[a][s-1][FX_W-1]};
                ge[a][s]        = trial[a][s] >= {1'b0, focal[a]};
                rem_next[a][s]  = ge[a][s] ? CFG_W'(trial[a][s] - {1'b0, focal[a]})
                                           : trial[a][s][CFG_W-1:0];
                w_next[a][s]    = {w_reg[a][s-1][FX_W-2:0], ge[a][s]};
                neg_next[a][s]  = neg_reg[a][s-1];
                ovf_next[a][s]  = ovf_reg[a][s-1];
                zero_next[a][s] = zero_reg[a][s-1];
            end
            big[a] = ovf_reg[a][DIV_STEPS] || w_reg[a][DIV_STEPS][FX_W-1];
            if (zero_reg[a][DIV_STEPS])
            begin
                n_next[a] = '0;
            end
            else if (!neg_reg[a][DIV_STEPS])
            begin
                n_next[a] = big[a] ? FX_MAX_Q
                                   : $signed({1'b0, w_reg[a][DIV_STEPS][FX_W-2:0]});
            end
            else
            begin
                n_next[a] = big[a] ? FX_MIN_Q
                                   : -$signed({1'b0, w_reg[a][DIV_STEPS][FX_W-2:0]});
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (go[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < NST; i++)
            begin
                if (go[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int a = 0; a < 2; a++)
        begin
            for (int s = 0; s <= DIV_STEPS; s++)
            begin
                if (go[s])
                begin
                    rem_reg[a][s]  <= rem_next[a][s];
                    w_reg[a][s]    <= w_next[a][s];
                    neg_reg[a][s]  <= neg_next[a][s];
                    ovf_reg[a][s]  <= ovf_next[a][s];
                    zero_reg[a][s] <= zero_next[a][s];
                end
            end
            if (go[NST-1])
            begin
                n_reg[a] <= n_next[a];
            end
        end
    end

    assign in_ready  = go[0];
    assign out_valid = v_reg[NST-1];
    assign nx        = n_reg[0];
    assign ny        = n_reg[1];

endmodule

// ----- src/udm_warp.sv -----
module udm_warp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  udm_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [udm_pkg::FX_W-1:0] nx,
    input  logic signed [udm_pkg::FX_W-1:0] ny,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic signed [udm_pkg::FX_W-1:0] sx,
    output logic signed [udm_pkg::FX_W-1:0] sy
);
    import udm_pkg::*;

    localparam int WST = 10;

    logic [WST-1:0] v_reg;
    logic [WST-1:0] go;

    logic signed [FX_W-1:0] nx_reg [8];
    logic signed [FX_W-1:0] ny_reg [8];

    logic signed [49:0]     pxx_reg, pyy_reg, pxy_reg;
    logic signed [FX_W-1:0] xx1_reg, yy1_reg, xy1_reg, r21_reg;
    logic signed [49:0]     r4p_reg;
    logic signed [FX_W-1:0] xx2_reg, yy2_reg, xy2_reg, r22_reg;
    logic signed [FX_W-1:0] r4_reg;
    logic signed [FX_W-1:0] xx3_reg, yy3_reg, xy3_reg, r23_reg;
    logic signed [49:0]     r6p_reg;
    logic signed [40:0]     k1p_reg, k2p_reg;
    logic signed [26:0]     sx2_reg, sy2_reg;
    logic signed [FX_W-1:0] xy4_reg;
    logic signed [FX_W-1:0] r6_reg;
    logic signed [27:0]     t12_reg;
    logic signed [40:0]     a1_reg, b2_reg;
    logic signed [42:0]     a2_reg, b1_reg;
    logic signed [40:0]     k3p_reg;
    logic signed [27:0]     t12b_reg;
    logic signed [29:0]     tx_reg, ty_reg;
    logic signed [FX_W-1:0] f_reg;
    logic signed [29:0]     tx7_reg, ty7_reg;
    logic signed [49:0]     nxf_reg, nyf_reg;
    logic signed [29:0]     tx8_reg, ty8_reg;
    logic signed [FX_W-1:0] sx_reg, sy_reg;

    logic signed [FX_W-1:0] f_next, sx_next, sy_next;

    always_comb
    begin
        go[WST-1] = !v_reg[WST-1] || out_ready;
        for (int i = WST - 2; i >= 0; i--)
        begin
            go[i] = !v_reg[i] || go[i+1];
        end
    end

    always_comb
    begin
        f_next  = sat_fx(FX_ONE + 64'(t12b_reg) + (64'(k3p_reg) >>> 14));
        sx_next = sat_fx((64'(nxf_reg) >>> 20) + 64'(tx8_reg));
        sy_next = sat_fx((64'(nyf_reg) >>> 20) + 64'(ty8_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (go[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int i = 1; i < WST; i++)
            begin
                if (go[i])
                begin
                    v_reg[i] <= v_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            pxx_reg   <= nx * nx;
            pyy_reg   <= ny * ny;
            pxy_reg   <= nx * ny;
            nx_reg[0] <= nx;
            ny_reg[0] <= ny;
        end
        for (int i = 1; i < 8; i++)
        begin
            if (go[i])
            begin
                nx_reg[i] <= nx_reg[i-1];
                ny_reg[i] <= ny_reg[i-1];
            end
        end
        if (go[1])
        begin
            xx1_reg <= sat_fx(64'(pxx_reg) >>> 20);
            yy1_reg <= sat_fx(64'(pyy_reg) >>> 20);
            xy1_reg <= sat_fx(64'(pxy_reg) >>> 20);
            r21_reg <= sat_fx((64'(pxx_reg) + 64'(pyy_reg)) >>> 20);
        end
        if (go[2])
        begin
            r4p_reg <= r21_reg * r21_reg;
            xx2_reg <= xx1_reg;
            yy2_reg <= yy1_reg;
            xy2_reg <= xy1_reg;
            r22_reg <= r21_reg;
        end
        if (go[3])
        begin
            r4_reg  <= sat_fx(64'(r4p_reg) >>> 20);
            xx3_reg <= xx2_reg;
            yy3_reg <= yy2_reg;
            xy3_reg <= xy2_reg;
            r23_reg <= r22_reg;
        end
        if (go[4])
        begin
            r6p_reg <= r4_reg * r23_reg;
            k1p_reg <= cfg.radial_k1 * r23_reg;
            k2p_reg <= cfg.radial_k2 * r4_reg;
            sx2_reg <= 27'(r23_reg) + 27'(xx3_reg) + 27'(xx3_reg);
            sy2_reg <= 27'(r23_reg) + 27'(yy3_reg) + 27'(yy3_reg);
            xy4_reg <= xy3_reg;
        end
        if (go[5])
        begin
            r6_reg  <= sat_fx(64'(r6p_reg) >>> 20);
            t12_reg <= 28'((64'(k1p_reg) >>> 14) + (64'(k2p_reg) >>> 14));
            a1_reg  <= cfg.tang_p1 * xy4_reg;
            a2_reg  <= cfg.tang_p2 * sx2_reg;
            b1_reg  <= cfg.tang_p1 * sy2_reg;
            b2_reg  <= cfg.tang_p2 * xy4_reg;
        end
        if (go[6])
        begin
            k3p_reg  <= cfg.radial_k3 * r6_reg;
            t12b_reg <= t12_reg;
            tx_reg   <= 30'((64'(a1_reg) >>> 13) + (64'(a2_reg) >>> 14));
            ty_reg   <= 30'((64'(b1_reg) >>> 14) + (64'(b2_reg) >>> 13));
        end
        if (go[7])
        begin
            f_reg   <= f_next;
            tx7_reg <= tx_reg;
            ty7_reg <= ty_reg;
        end
        if (go[8])
        begin
            nxf_reg <= nx_reg[7] * f_reg;
            nyf_reg <= ny_reg[7] * f_reg;
            tx8_reg <= tx7_reg;
            ty8_reg <= ty7_reg;
        end
        if (go[9])
        begin
            sx_reg <= sx_next;
            sy_reg <= sy_next;
        end
    end

    assign in_ready  = go[0];
    assign out_valid = v_reg[WST-1];
    assign sx        = sx_reg;
    assign sy        = sy_reg;

endmodule

// ----- src/udm_proj.sv -----
module udm_proj (
    input  logic                            clk,
    input  logic                            rst_n,
    input  udm_pkg::cfg_t                   cfg,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [udm_pkg::FX_W-1:0] sx,
    input  logic signed [udm_pkg::FX_W-1:0] sy,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [udm_pkg::PIX_X_W-1:0]     source_x,
    output logic [udm_pkg::PIX_Y_W-1:0]     source_y,
    output logic                            inside_res
);
    import udm_pkg::*;

    localparam int PST = 2;
    localparam logic signed [28:0] LIM_X = 29'(IMAGE_WIDTH * 1024);
    localparam logic signed [28:0] LIM_Y = 29'(IMAGE_HEIGHT * 1024);

    logic [PST-1:0] v_reg;
    logic [PST-1:0] go;

    logic signed [47:0]        mx_reg, my_reg;
    logic signed [28:0]        qx_next, qy_next;
    logic                      inside_next;
    logic [PIX_X_W-1:0]        source_x_reg;
    logic [PIX_Y_W-1:0]        source_y_reg;
    logic                      inside_reg;

    always_comb
    begin
        go[PST-1] = !v_reg[PST-1] || out_ready;
        go[0]     = !v_reg[0] || go[1];
    end

    always_comb
    begin
        qx_next     = 29'((64'(mx_reg) >>> 20) + 64'($signed({1'b0, cfg.centre_x})));
        qy_next     = 29'((64'(my_reg) >>> 20) + 64'($signed({1'b0, cfg.centre_y})));
        inside_next = !qx_next[28] && (qx_next < LIM_X)
                   && !qy_next[28] && (qy_next < LIM_Y);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (go[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (go[1])
            begin
                v_reg[1] <= v_reg[0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go[0])
        begin
            mx_reg <= sx * $signed({1'b0, cfg.focal_x});
            my_reg <= sy * $signed({1'b0, cfg.focal_y});
        end
        if (go[1])
        begin
            source_x_reg <= inside_next ? qx_next[10 +: PIX_X_W] : '0;
            source_y_reg <= inside_next ? qy_next[10 +: PIX_Y_W] : '0;
            inside_reg   <= inside_next;
        end
    end

    assign in_ready   = go[0];
    assign out_valid  = v_reg[PST-1];
    assign source_x   = source_x_reg;
    assign source_y   = source_y_reg;
    assign inside_res = inside_reg;

endmodule

// ----- src/lens_undistortion_map_core.sv -----
// Channel  | Direction | Handshake            | Word
// pixel    | in        | in_valid / in_stall  | pixel_x, pixel_y
// source   | out       | out_valid / out_stall| source_x, source_y, inside_res
// config   | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One word per cycle while out_stall is low; words pass the divider, warp and projection stages.
// Latency is set by the bit-per-stage normalizing divider, one per axis.
// rst_n clears all stage valids and loads the default intrinsics; no clearing pass.
// A stalled output holds; in_stall rises only when every stage holds a word.
// cfg_ready is always high; write registers only while the pipeline is empty.
module lens_undistortion_map_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [udm_pkg::PIX_X_W-1:0] pixel_x,
    input  logic [udm_pkg::PIX_Y_W-1:0] pixel_y,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [udm_pkg::PIX_X_W-1:0] source_x,
    output logic [udm_pkg::PIX_Y_W-1:0] source_y,
    output logic                        inside_res,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [udm_pkg::IDX_W-1:0]   cfg_index,
    input  logic [udm_pkg::DATA_W-1:0]  cfg_data
);
    import udm_pkg::*;

    `include "assert_macros.svh"

    cfg_t                   cfg;
    logic                   norm_ready, norm_valid;
    logic                   warp_ready, warp_valid;
    logic                   proj_ready;
    logic signed [FX_W-1:0] nx, ny, sx, sy;

    assign cfg_ready = 1'b1;

    udm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    udm_norm u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (in_valid),
        .in_ready  (norm_ready),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .out_valid (norm_valid),
        .out_ready (warp_ready),
        .nx        (nx),
        .ny        (ny)
    );

    udm_warp u_warp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (norm_valid),
        .in_ready  (warp_ready),
        .nx        (nx),
        .ny        (ny),
        .out_valid (warp_valid),
        .out_ready (proj_ready),
        .sx        (sx),
        .sy        (sy)
    );

    udm_proj u_proj (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .in_valid   (warp_valid),
        .in_ready   (proj_ready),
        .sx         (sx),
        .sy         (sy),
        .out_valid  (out_valid),
        .out_ready  (!out_stall),
        .source_x   (source_x),
        .source_y   (source_y),
        .inside_res (inside_res)
    );

    assign in_stall = !norm_ready;

    `UDM_ASSERT(a_stall_full, clk, rst_n, !in_stall || (out_valid && out_stall), "input stalled while pipeline has room")
    `UDM_ASSERT_IMPL(a_outside_zero, clk, rst_n, out_valid && !inside_res, source_x == '0 && source_y == '0, "outside word carries coordinates")
    `UDM_ASSERT_IMPL(a_inside_bound, clk, rst_n, out_valid && inside_res, {3'b0, source_y} < 12'(IMAGE_HEIGHT) || IMAGE_HEIGHT > 512, "inside row out of image")

endmodule
